/* src/bpfa_pkg.sv */
package bpfa_pkg;

  // field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned PAGE_W   = 16;
  localparam int unsigned CNT_W    = 17;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned BIT_W    = 6;
  localparam int unsigned END_W    = 7;

  // highest frame count a request may search
  localparam int unsigned PAGE_LIMIT = 65536;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_REQUEST   = 3'd0,
    OP_LOCK      = 3'd1,
    OP_FREE      = 3'd2,
    OP_RESERVE   = 3'd3,
    OP_UNRESERVE = 3'd4
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRCH,
    ST_RANGE,
    ST_DONE
  } state_e;

  // control for the shared word unit
  typedef struct packed {
    logic              search;
    logic              set_val;
    logic [BIT_W-1:0]  lo_bit;
    logic [END_W-1:0]  hi_end;
  } wu_ctrl_t;

  // status from the shared word unit
  typedef struct packed {
    logic              all_set;
    logic [BIT_W-1:0]  zero_bit;
  } wu_stat_t;

endpackage

/* src/bpfa_in_if.sv */
interface bpfa_in_if import bpfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [PAGE_W-1:0] first_page;
  logic [CNT_W-1:0]  page_count;

  modport source (output valid, output op, output first_page, output page_count,
                  input ready);
  modport sink   (input valid, input op, input first_page, input page_count,
                  output ready);
endinterface

/* src/bpfa_out_if.sv */
interface bpfa_out_if import bpfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;
  logic              out_of_pages;
  logic [CNT_W-1:0]  free_pages;
  logic [CNT_W-1:0]  used_pages;
  logic [CNT_W-1:0]  reserved_pages;

  modport source (output valid, output page, output out_of_pages, output free_pages,
                  output used_pages, output reserved_pages, input ready);
  modport sink   (input valid, input page, input out_of_pages, input free_pages,
                  input used_pages, input reserved_pages, output ready);
endinterface

/* src/bpfa_ram.sv */
module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/bpfa_word_unit.sv */
module bpfa_word_unit import bpfa_pkg::*; (
  input  logic [WORD_W-1:0] word_i,
  input  wu_ctrl_t          ctrl_i,
  output logic [WORD_W-1:0] word_o,
  output wu_stat_t          stat_o
);

  logic [WORD_W-1:0] inc;
  logic [WORD_W-1:0] iso;
  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] mask;
  logic [END_W-1:0]  hi_shift;
  logic [BIT_W-1:0]  idx;

  // isolate the lowest clear bit
  assign inc = word_i + WORD_W'(1);
  assign iso = ~word_i & inc;

  // one-hot to index, each output bit an independent or
  always_comb begin
    idx = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (iso[j]) begin
        idx = idx | BIT_W'(j);
      end
    end
  end

  // range mask: bits lo_bit up to hi_end-1
  assign hi_shift = END_W'(WORD_W) - ctrl_i.hi_end;
  assign lo_mask  = {WORD_W{1'b1}} << ctrl_i.lo_bit;
  assign hi_mask  = {WORD_W{1'b1}} >> hi_shift;
  assign mask     = lo_mask & hi_mask;

  // merged word: take lowest clear bit, or set / clear the range
  always_comb begin
    if (ctrl_i.search) begin
      word_o = word_i | inc;
    end else if (ctrl_i.set_val) begin
      word_o = word_i | mask;
    end else begin
      word_o = word_i & ~mask;
    end
  end

  assign stat_o.all_set  = &word_i;
  assign stat_o.zero_bit = idx;

endmodule

/* src/bitmap_page_frame_allocator.sv */
// Bitmap page frame allocator. One bit per page frame lives in a RAM of 64-bit
// words; three 17-bit counters (free, used, reserved) wrap modulo 2^17 and are
// shown with every result. After reset the block clears the bitmap one word per
// cycle with in_i.ready low; writes of total_pages are taken meanwhile. One item
// is in work at a time. A request scans words one per cycle from a hint (the
// lowest word that may hold a clear bit); a range operation reads and rewrites
// each 64-frame word it covers in turn; an empty range or an unused op goes
// straight to its result. The result waits in an output register, and the next
// item is accepted while it waits.
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int NUM_FRAMES = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bpfa_in_if.sink          in_i,
  bpfa_out_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  localparam int WORDS     = (NUM_FRAMES + WORD_W - 1) / WORD_W;
  localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FW        = ($clog2(NUM_FRAMES) + 1 > 18) ? $clog2(NUM_FRAMES) + 1 : 18;
  localparam int LIMIT     = (NUM_FRAMES < PAGE_LIMIT) ? NUM_FRAMES : PAGE_LIMIT;
  localparam int SW        = (LIMIT + WORD_W - 1) / WORD_W;
  localparam int FRW       = AW + BIT_W + 1;

  localparam logic [AW-1:0]  LAST_WORD = AW'(WORDS - 1);
  localparam logic [AW-1:0]  SRCH_LAST = AW'(SW - 1);
  localparam logic [FW-1:0]  NF        = FW'(NUM_FRAMES);
  localparam logic [FRW-1:0] LIMIT_V   = FRW'(LIMIT);

  state_e            state_q, state_d;
  logic [AW-1:0]     w_q, w_d;
  logic [AW-1:0]     hint_q, hint_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]     lo_word_q, lo_word_d;
  logic [AW-1:0]     last_q, last_d;
  logic [BIT_W-1:0]  lo_bit_q, lo_bit_d;
  logic [END_W-1:0]  hi_end_q, hi_end_d;
  logic              found_q, found_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic              oop_q, oop_d;

  logic              out_vld_q;
  logic [PAGE_W-1:0] out_page_q;
  logic              out_oop_q;
  logic [CNT_W-1:0]  free_q, used_q, resv_q;

  logic              load;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  wu_ctrl_t          wu_ctrl;
  wu_stat_t          wu_stat;
  logic [WORD_W-1:0] wu_word;

  logic [FW-1:0]     rng_lo;
  logic [FW-1:0]     rng_end;
  logic [FW-1:0]     rng_hi;
  logic [FW-1:0]     rng_last;
  logic              rng_any;
  logic [AW-1:0]     rng_lo_word;
  logic [FRW-1:0]    frame;
  logic              is_set_op;

  // bitmap store
  bpfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bpfa_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared word unit: mask merge and lowest clear bit
  bpfa_word_unit u_bpfa_word_unit (
    .word_i (ram_rdata),
    .ctrl_i (wu_ctrl),
    .word_o (wu_word),
    .stat_o (wu_stat)
  );

  // range bounds of the incoming beat, clipped to the store
  assign rng_lo      = FW'(in_i.first_page);
  assign rng_end     = rng_lo + FW'(in_i.page_count);
  assign rng_hi      = (rng_end > NF) ? NF : rng_end;
  assign rng_any     = rng_hi > rng_lo;
  assign rng_last    = rng_hi - FW'(1);
  assign rng_lo_word = AW'(rng_lo >> BIT_W);

  assign is_set_op = (op_q == OP_LOCK) || (op_q == OP_RESERVE);
  assign frame     = {1'b0, w_q, wu_stat.zero_bit};

  // word unit control
  always_comb begin
    wu_ctrl.search  = (state_q == ST_SRCH);
    wu_ctrl.set_val = is_set_op;
    wu_ctrl.lo_bit  = (w_q == lo_word_q) ? lo_bit_q : '0;
    wu_ctrl.hi_end  = (w_q == last_q) ? hi_end_q : END_W'(WORD_W);
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer next state and datapath control
  always_comb begin
    state_d   = state_q;
    w_d       = w_q;
    hint_d    = hint_q;
    op_d      = op_q;
    cnt_d     = cnt_q;
    lo_word_d = lo_word_q;
    last_d    = last_q;
    lo_bit_d  = lo_bit_q;
    hi_end_d  = hi_end_q;
    found_d   = found_q;
    page_d    = page_q;
    oop_d     = oop_q;
    load      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = w_q;
    ram_wdata = wu_word;
    ram_raddr = w_q + AW'(1);
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (w_q == LAST_WORD) begin
          w_d     = '0;
          state_d = ST_IDLE;
        end else begin
          w_d = w_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          op_d      = in_i.op;
          cnt_d     = in_i.page_count;
          lo_word_d = rng_lo_word;
          last_d    = AW'(rng_last >> BIT_W);
          lo_bit_d  = in_i.first_page[BIT_W-1:0];
          hi_end_d  = {1'b0, rng_last[BIT_W-1:0]} + END_W'(1);
          found_d   = 1'b0;
          page_d    = '0;
          oop_d     = 1'b0;
          case (in_i.op)
            OP_REQUEST: begin
              w_d       = hint_q;
              ram_raddr = hint_q;
              state_d   = ST_SRCH;
            end
            OP_LOCK, OP_FREE, OP_RESERVE, OP_UNRESERVE: begin
              if (rng_any) begin
                w_d       = rng_lo_word;
                ram_raddr = rng_lo_word;
                state_d   = ST_RANGE;
                if ((in_i.op == OP_FREE || in_i.op == OP_UNRESERVE) &&
                    (rng_lo_word < hint_q)) begin
                  hint_d = rng_lo_word;
                end
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SRCH: begin
        if (!wu_stat.all_set) begin
          if (frame < LIMIT_V) begin
            ram_we  = 1'b1;
            found_d = 1'b1;
            page_d  = PAGE_W'(frame);
            hint_d  = w_q;
          end else begin
            oop_d = 1'b1;
          end
          state_d = ST_DONE;
        end else if (w_q == SRCH_LAST) begin
          oop_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          w_d = w_q + AW'(1);
        end
      end
      ST_RANGE: begin
        ram_we = 1'b1;
        if (w_q == last_q) begin
          state_d = ST_DONE;
        end else begin
          w_d = w_q + AW'(1);
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      w_q     <= '0;
      hint_q  <= '0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      hint_q  <= hint_d;
    end
  end

  // operation payload
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    cnt_q     <= cnt_d;
    lo_word_q <= lo_word_d;
    last_q    <= last_d;
    lo_bit_q  <= lo_bit_d;
    hi_end_q  <= hi_end_d;
    found_q   <= found_d;
    page_q    <= page_d;
    oop_q     <= oop_d;
  end

  // page counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '0;
      used_q <= '0;
      resv_q <= '0;
    end else if (cfg_we_i) begin
      free_q <= cfg_wdata_i;
      used_q <= '0;
      resv_q <= '0;
    end else if (load) begin
      case (op_q)
        OP_REQUEST: begin
          if (found_q) begin
            free_q <= free_q - CNT_W'(1);
            used_q <= used_q + CNT_W'(1);
          end
        end
        OP_LOCK: begin
          free_q <= free_q - cnt_q;
          used_q <= used_q + cnt_q;
        end
        OP_FREE: begin
          free_q <= free_q + cnt_q;
          used_q <= used_q - cnt_q;
        end
        OP_RESERVE: begin
          free_q <= free_q - cnt_q;
          resv_q <= resv_q + cnt_q;
        end
        OP_UNRESERVE: begin
          free_q <= free_q + cnt_q;
          resv_q <= resv_q - cnt_q;
        end
        default: begin
          free_q <= free_q;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_page_q <= page_q;
      out_oop_q  <= oop_q;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.page           = out_page_q;
  assign out_o.out_of_pages   = out_oop_q;
  assign out_o.free_pages     = free_q;
  assign out_o.used_pages     = used_q;
  assign out_o.reserved_pages = resv_q;

endmodule

/* src/bpfa_checker.sv */
module bpfa_checker import bpfa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [PAGE_W-1:0] page_i,
  input logic              oop_i,
  input logic [CNT_W-1:0]  free_i,
  input logic [CNT_W-1:0]  used_i,
  input logic [CNT_W-1:0]  resv_i,
  input logic              cfg_we_i,
  input logic [CNT_W-1:0]  cfg_wdata_i
);

  // a stalled result beat holds its page and flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(page_i) && $stable(oop_i))
    else $error("stalled result beat changed");

  // a failed request grants no page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && oop_i |-> page_i == '0)
    else $error("out of pages with non-zero page");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item is in work");

  // total_pages write loads the counters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> free_i == $past(cfg_wdata_i) && used_i == '0 && resv_i == '0)
    else $error("counters not loaded by total_pages write");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .page_i      (out_o.page),
  .oop_i       (out_o.out_of_pages),
  .free_i      (out_o.free_pages),
  .used_i      (out_o.used_pages),
  .resv_i      (out_o.reserved_pages),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i)
);

/* tb/tb_bitmap_page_frame_allocator.sv */
module tb_bitmap_page_frame_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import bpfa_pkg::*;

  localparam int unsigned NUM_FRAMES    = 65536;
  localparam int unsigned MAP_WORDS     = (NUM_FRAMES + 63) / 64;
  localparam int unsigned SEARCH_TOP    = (NUM_FRAMES < PAGE_LIMIT) ? NUM_FRAMES : PAGE_LIMIT;
  localparam int unsigned FULL_RANGE    = 65536;
  localparam int unsigned DIR_ROWS      = 24;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned RAND_PER_PHASE = 260;
  localparam int unsigned CYCLE_LIMIT   = 8000000;

  // op codes the block leaves alone
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              out_of_pages;
    logic [CNT_W-1:0]  free_pages;
    logic [CNT_W-1:0]  used_pages;
    logic [CNT_W-1:0]  reserved_pages;
  } alloc_result_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] first;
    logic [CNT_W-1:0]  count;
    bit                typed;
    alloc_result_t     res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  bpfa_in_if  alloc_in ();
  bpfa_out_if alloc_out ();

  bitmap_page_frame_allocator #(.NUM_FRAMES(NUM_FRAMES)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (alloc_in),
    .out_o       (alloc_out),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10ns clk_i = ~clk_i;

  // shadow copy of the allocator state
  bit   [63:0]      shadow_map [MAP_WORDS];
  logic [CNT_W-1:0] shadow_free;
  logic [CNT_W-1:0] shadow_used;
  logic [CNT_W-1:0] shadow_rsvd;

  alloc_result_t    pending_results [$];
  int unsigned      fail_cnt   = 0;
  int unsigned      beats_sent = 0;
  bit               quiet_run  = 1'b0;

  // directed items; typed rows carry the result straight after the first write of 65536
  dir_row_t dir_table [DIR_ROWS] = '{
    '{OP_REQUEST,   16'd0,      17'd0,      1'b1, '{16'd0, 1'b0, 17'd65535, 17'd1, 17'd0}},
    '{OP_REQUEST,   16'd0,      17'd0,      1'b1, '{16'd1, 1'b0, 17'd65534, 17'd2, 17'd0}},
    '{OP_LOCK,      16'd0,      17'd0,      1'b1, '{16'd0, 1'b0, 17'd65534, 17'd2, 17'd0}},
    '{OP_RSVD5,     16'hFFFF,   17'd65536,  1'b1, '{16'd0, 1'b0, 17'd65534, 17'd2, 17'd0}},
    '{OP_RSVD6,     16'h5555,   17'h0AAAA,  1'b1, '{16'd0, 1'b0, 17'd65534, 17'd2, 17'd0}},
    '{OP_RSVD7,     16'hAAAA,   17'h15555,  1'b1, '{16'd0, 1'b0, 17'd65534, 17'd2, 17'd0}},
    '{OP_LOCK,      16'hFFFF,   17'd65536,  1'b0, '0},
    '{OP_REQUEST,   16'd0,      17'd0,      1'b0, '0},
    '{OP_RESERVE,   16'd64,     17'd128,    1'b0, '0},
    '{OP_REQUEST,   16'd0,      17'd0,      1'b0, '0},
    '{OP_UNRESERVE, 16'd64,     17'd128,    1'b0, '0},
    '{OP_FREE,      16'd0,      17'd1,      1'b0, '0},
    '{OP_REQUEST,   16'd0,      17'd0,      1'b0, '0},
    '{OP_LOCK,      16'd0,      17'd65536,  1'b0, '0},
    '{OP_REQUEST,   16'd0,      17'd0,      1'b0, '0},
    '{OP_FREE,      16'hFFFF,   17'd1,      1'b0, '0},
    '{OP_REQUEST,   16'd0,      17'd0,      1'b0, '0},
    '{OP_REQUEST,   16'd0,      17'd0,      1'b0, '0},
    '{OP_UNRESERVE, 16'd1000,   17'd1,      1'b0, '0},
    '{OP_REQUEST,   16'd0,      17'd0,      1'b0, '0},
    '{OP_FREE,      16'd0,      17'd65536,  1'b0, '0},
    '{OP_RESERVE,   16'hFFFF,   17'd1,      1'b0, '0},
    '{OP_FREE,      16'h8000,   17'h10000,  1'b0, '0},
    '{OP_REQUEST,   16'd0,      17'd0,      1'b0, '0}
  };

  // set or clear a run of frames, ignoring those past the store
  function automatic void mark_frames(logic [PAGE_W-1:0] first, logic [CNT_W-1:0] count,
                                      bit value);
    int unsigned stop;
    stop = int'(first) + int'(count);
    if (stop > NUM_FRAMES) stop = NUM_FRAMES;
    for (int unsigned f = first; f < stop; f++) begin
      shadow_map[f >> 6][f & 63] = value;
    end
  endfunction

  // apply one operation to the shadow state and return the result it gives
  function automatic alloc_result_t apply_op(logic [OP_W-1:0] op, logic [PAGE_W-1:0] first,
                                             logic [CNT_W-1:0] count);
    alloc_result_t r;
    int unsigned   frame;
    bit            found;
    r     = '0;
    frame = 0;
    found = 1'b0;
    case (op)
      OP_REQUEST: begin
        // lowest clear frame, skipping full words
        for (int unsigned w = 0; w < MAP_WORDS && !found; w++) begin
          if (shadow_map[w] != '1) begin
            for (int unsigned b = 0; b < 64 && !found; b++) begin
              if (!shadow_map[w][b]) begin
                frame = w * 64 + b;
                found = 1'b1;
              end
            end
          end
        end
        if (found && frame < SEARCH_TOP) begin
          shadow_map[frame >> 6][frame & 63] = 1'b1;
          shadow_free = shadow_free - 1'b1;
          shadow_used = shadow_used + 1'b1;
          r.page = frame[PAGE_W-1:0];
        end else begin
          r.out_of_pages = 1'b1;
        end
      end
      OP_LOCK: begin
        mark_frames(first, count, 1'b1);
        shadow_free = shadow_free - count;
        shadow_used = shadow_used + count;
      end
      OP_FREE: begin
        mark_frames(first, count, 1'b0);
        shadow_free = shadow_free + count;
        shadow_used = shadow_used - count;
      end
      OP_RESERVE: begin
        mark_frames(first, count, 1'b1);
        shadow_free = shadow_free - count;
        shadow_rsvd = shadow_rsvd + count;
      end
      OP_UNRESERVE: begin
        mark_frames(first, count, 1'b0);
        shadow_free = shadow_free + count;
        shadow_rsvd = shadow_rsvd - count;
      end
      default: begin
      end
    endcase
    r.free_pages     = shadow_free;
    r.used_pages     = shadow_used;
    r.reserved_pages = shadow_rsvd;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // load total_pages; the bitmap is left as it is
  task automatic write_total(logic [CNT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    shadow_free = value;
    shadow_used = '0;
    shadow_rsvd = '0;
    cfg_we_i    <= 1'b0;
  endtask

  // one input beat, with a random gap in front of it
  task automatic send_beat(logic [OP_W-1:0] op, logic [PAGE_W-1:0] first,
                           logic [CNT_W-1:0] count, bit typed = 1'b0,
                           alloc_result_t typed_res = '0);
    alloc_result_t predicted;
    if (!quiet_run) begin
      while ($urandom_range(99) < 29) begin
        alloc_in.valid      <= 1'b0;
        alloc_in.op         <= OP_W'($urandom);
        alloc_in.first_page <= PAGE_W'($urandom);
        alloc_in.page_count <= CNT_W'($urandom);
        @(posedge clk_i);
      end
    end
    alloc_in.valid      <= 1'b1;
    alloc_in.op         <= op;
    alloc_in.first_page <= first;
    alloc_in.page_count <= count;
    do @(posedge clk_i); while (!alloc_in.ready);
    predicted = apply_op(op, first, count);
    pending_results.push_back(typed ? typed_res : predicted);
    beats_sent++;
  endtask

  // mostly short runs, now and then the whole store
  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return CNT_W'($urandom_range(200));
    if (r < 92) return CNT_W'($urandom_range(4096));
    if (r < 97) return CNT_W'($urandom_range(FULL_RANGE));
    return CNT_W'(FULL_RANGE);
  endfunction

  task automatic random_beat();
    int unsigned       pick;
    logic [PAGE_W-1:0] first;
    pick  = $urandom_range(99);
    first = $urandom_range(1) ? PAGE_W'($urandom_range(1023)) : PAGE_W'($urandom);
    if (pick < 40) begin
      send_beat(OP_REQUEST, PAGE_W'($urandom), CNT_W'($urandom_range(FULL_RANGE)));
    end else if (pick < 52) begin
      send_beat(OP_LOCK, first, pick_count());
    end else if (pick < 64) begin
      send_beat(OP_FREE, first, pick_count());
    end else if (pick < 74) begin
      send_beat(OP_RESERVE, first, pick_count());
    end else if (pick < 84) begin
      send_beat(OP_UNRESERVE, first, pick_count());
    end else if (pick < 88) begin
      send_beat(OP_W'($urandom_range(OP_RSVD5, OP_RSVD7)), PAGE_W'($urandom),
                CNT_W'($urandom_range(FULL_RANGE)));
    end else if (pick < 90) begin
      // fill the store, run dry, hand a few frames back
      send_beat(OP_LOCK, '0, CNT_W'(FULL_RANGE));
      repeat ($urandom_range(1, 3)) send_beat(OP_REQUEST, '0, '0);
      send_beat(OP_FREE, PAGE_W'($urandom), CNT_W'($urandom_range(1, 8)));
      repeat (2) send_beat(OP_REQUEST, '0, '0);
      if ($urandom_range(1)) send_beat(OP_FREE, '0, CNT_W'(FULL_RANGE));
    end else begin
      send_beat(OP_REQUEST, '0, '0);
    end
  endtask

  // result side stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_out.ready <= 1'b0;
    end else begin
      alloc_out.ready <= quiet_run || ($urandom_range(99) >= 29);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    alloc_result_t want;
    if (rst_ni && alloc_out.valid && alloc_out.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual page %0d free %0d",
                 $time, alloc_out.page, alloc_out.free_pages);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("page", want.page, alloc_out.page);
        check_field("out_of_pages", want.out_of_pages, alloc_out.out_of_pages);
        check_field("free_pages", want.free_pages, alloc_out.free_pages);
        check_field("used_pages", want.used_pages, alloc_out.used_pages);
        check_field("reserved_pages", want.reserved_pages, alloc_out.reserved_pages);
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [CNT_W-1:0] totals [PHASES];
    totals = '{CNT_W'(65536), CNT_W'(0), CNT_W'($urandom_range(1, 65535)), CNT_W'(1),
               CNT_W'(65536)};
    for (int unsigned w = 0; w < MAP_WORDS; w++) shadow_map[w] = '0;
    shadow_free = '0;
    shadow_used = '0;
    shadow_rsvd = '0;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    alloc_in.valid      <= 1'b0;
    alloc_in.op         <= '0;
    alloc_in.first_page <= '0;
    alloc_in.page_count <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      write_total(totals[ph]);
      if (ph == 0) begin
        foreach (dir_table[i]) begin
          send_beat(dir_table[i].op, dir_table[i].first, dir_table[i].count,
                    dir_table[i].typed, dir_table[i].res);
        end
      end
      // one phase runs with neither side idling
      quiet_run = (ph == 2);
      while (beats_sent < DIR_ROWS + (ph + 1) * RAND_PER_PHASE) random_beat();
      alloc_in.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      quiet_run = 1'b0;
    end

    // catch any stray beat
    repeat (16) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
src/bpfa_pkg.sv
src/bpfa_in_if.sv
src/bpfa_out_if.sv
src/bpfa_ram.sv
src/bpfa_word_unit.sv
src/bitmap_page_frame_allocator.sv
src/bpfa_checker.sv
tb/tb_bitmap_page_frame_allocator.sv
